@@ rtl/pppz_pkg.sv @@
// package for the perspective point plotter: frame geometry, widths and constants
package pppz_pkg;

  localparam int SCREEN_COLS = 120;
  localparam int SCREEN_ROWS = 40;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int CELL_W      = $clog2(CELL_COUNT);

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int FOCAL_W = 8;
  localparam int SYM_W   = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int DEPTH_W = 24;
  localparam int NUM_W   = DIFF_W + 12;
  localparam int BIT_W   = $clog2(COL_W);
  localparam int CFG_IDX_W = 2;

  localparam int MIN_DZ = 26;

  localparam logic [SYM_W-1:0]   BLANK_SYM = SYM_W'(32);
  localparam logic [DEPTH_W-1:0] FAR_DEPTH = DEPTH_W'(256000);

  localparam logic [COORD_W-1:0] CAM_X_RST = COORD_W'(0);
  localparam logic [COORD_W-1:0] CAM_Y_RST = COORD_W'(-1280);
  localparam logic [COORD_W-1:0] CAM_Z_RST = COORD_W'(-2560);
  localparam logic [FOCAL_W-1:0] FOCAL_RST = FOCAL_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 2'd3;

endpackage

@@ rtl/perspective_point_plot_zbuffer_top.sv @@
// perspective point plotter with depth-buffered character frame
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: x,y,z,symbol,cell_col,cell_row; tuser: mode
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: drawn,screen_col,screen_row,cell_symbol
//  cfg       in   cfg_we_i                       cfg_idx_i, cfg_data_i
//
// a read request passes the accept, read and write-back steps; a plot request passes accept, multiply,
// check, the serial divide of both quotients, read and write-back; a rejected plot ends at the check step
// one request is in flight at a time; the next is accepted once the block is idle again
// after reset a clearing pass over all 4800 cells fills both memories; no request is taken then
// a result waiting on m_axis_tready holds the next request in its read step, or in its check step if rejected
module perspective_point_plot_zbuffer_top
  import pppz_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_x, point_y, point_z, symbol, cell_col, cell_row, zero fill
  input  logic [95:0]          s_axis_tdata,
  // mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // drawn, screen_col, screen_row, cell_symbol, zero fill
  output logic [23:0]          m_axis_tdata
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MUL, S_CHK, S_DIV, S_RD, S_WB} state_e;

  state_e state_q;
  logic [CELL_W-1:0] clr_q;
  logic [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [FOCAL_W-1:0] focal_q;
  logic mode_q, in_rng_q;
  logic [SYM_W-1:0] sym_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [NUM_W-1:0] nc_q, nr_q;
  logic [COL_W-1:0] qc_q, qr_q;
  logic [BIT_W-1:0] bit_q;
  logic [CELL_W-1:0] addr_q;
  logic out_valid_q, drawn_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic [SYM_W-1:0] out_sym_q;

  logic [SYM_W-1:0]   sym_mem [CELL_COUNT];
  logic [DEPTH_W-1:0] dep_mem [CELL_COUNT];
  logic [SYM_W-1:0]   sym_rd_q;
  logic [DEPTH_W-1:0] dep_rd_q;

  logic mem_we;
  logic [CELL_W-1:0] mem_wa;
  logic [SYM_W-1:0] mem_wsym;
  logic [DEPTH_W-1:0] mem_wdep;

  logic accept;
  logic out_free, out_load;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic signed [NUM_W-1:0] nc_n, nr_n, lim_c, lim_r;
  logic [NUM_W-1:0] dsh;
  logic c_ge, r_ge, reject, depth_ok;
  logic [COL_W-1:0] qc_n, qr_n;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_col = s_axis_tdata[86:80];
  assign in_row = s_axis_tdata[92:87];

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = out_free && ((state_q == S_WB) || ((state_q == S_CHK) && reject));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_sym_q, out_row_q, out_col_q, drawn_q};

  always_comb begin
    nc_n = NUM_W'(dx_q) * NUM_W'($signed({1'b0, focal_q}))
         + NUM_W'(dz_q) * $signed(NUM_W'(SCREEN_COLS / 2));
    nr_n = NUM_W'(dy_q) * NUM_W'($signed({1'b0, focal_q}))
         + NUM_W'(dz_q) * $signed(NUM_W'(SCREEN_ROWS / 2));
    lim_c = NUM_W'(dz_q) * $signed(NUM_W'(SCREEN_COLS));
    lim_r = NUM_W'(dz_q) * $signed(NUM_W'(SCREEN_ROWS));
    reject = (dz_q < $signed(DIFF_W'(MIN_DZ))) || nc_q[NUM_W-1] || nr_q[NUM_W-1]
          || ($signed(nc_q) >= lim_c) || ($signed(nr_q) >= lim_r);
    dsh  = NUM_W'($unsigned(dz_q)) << bit_q;
    c_ge = nc_q >= dsh;
    r_ge = nr_q >= dsh;
    qc_n = qc_q;
    qr_n = qr_q;
    qc_n[bit_q] = c_ge;
    qr_n[bit_q] = r_ge;
    depth_ok = DEPTH_W'($unsigned(dz_q)) < dep_rd_q;
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = addr_q;
    mem_wsym = BLANK_SYM;
    mem_wdep = FAR_DEPTH;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
    end else if (state_q == S_WB) begin
      if (mode_q) begin
        mem_we = in_rng_q;
      end else begin
        mem_we   = depth_ok;
        mem_wsym = sym_q;
        mem_wdep = DEPTH_W'($unsigned(dz_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sym_mem[mem_wa] <= mem_wsym;
      dep_mem[mem_wa] <= mem_wdep;
    end
    sym_rd_q <= sym_mem[addr_q];
    dep_rd_q <= dep_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cam_x_q     <= CAM_X_RST;
      cam_y_q     <= CAM_Y_RST;
      cam_z_q     <= CAM_Z_RST;
      focal_q     <= FOCAL_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CAM_X: cam_x_q <= cfg_data_i;
          REG_CAM_Y: cam_y_q <= cfg_data_i;
          REG_CAM_Z: cam_z_q <= cfg_data_i;
          REG_FOCAL: focal_q <= cfg_data_i[FOCAL_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CELL_W'(CELL_COUNT - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            mode_q   <= s_axis_tuser;
            sym_q    <= s_axis_tdata[79:72];
            dx_q     <= $signed({s_axis_tdata[23], s_axis_tdata[23:0]})
                      - $signed({cam_x_q[COORD_W-1], cam_x_q});
            dy_q     <= $signed({s_axis_tdata[47], s_axis_tdata[47:24]})
                      - $signed({cam_y_q[COORD_W-1], cam_y_q});
            dz_q     <= $signed({s_axis_tdata[71], s_axis_tdata[71:48]})
                      - $signed({cam_z_q[COORD_W-1], cam_z_q});
            in_rng_q <= (32'(in_col) < SCREEN_COLS) && (32'(in_row) < SCREEN_ROWS);
            addr_q   <= CELL_W'(in_row) * CELL_W'(SCREEN_COLS) + CELL_W'(in_col);
            state_q  <= s_axis_tuser ? S_RD : S_MUL;
          end
        end
        S_MUL: begin
          nc_q    <= $unsigned(nc_n);
          nr_q    <= $unsigned(nr_n);
          state_q <= S_CHK;
        end
        S_CHK: begin
          qc_q  <= '0;
          qr_q  <= '0;
          bit_q <= BIT_W'(COL_W - 1);
          if (reject) begin
            if (out_free) begin
              drawn_q   <= 1'b0;
              out_col_q <= '0;
              out_row_q <= '0;
              out_sym_q <= '0;
              state_q   <= S_IDLE;
            end
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (c_ge) nc_q <= nc_q - dsh;
          if (r_ge) nr_q <= nr_q - dsh;
          qc_q  <= qc_n;
          qr_q  <= qr_n;
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            addr_q  <= CELL_W'(qr_n) * CELL_W'(SCREEN_COLS) + CELL_W'(qc_n);
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (out_free) state_q <= S_WB;
        end
        S_WB: begin
          if (mode_q) begin
            drawn_q   <= 1'b0;
            out_col_q <= '0;
            out_row_q <= '0;
            out_sym_q <= in_rng_q ? sym_rd_q : '0;
          end else begin
            drawn_q   <= depth_ok;
            out_col_q <= depth_ok ? qc_q : '0;
            out_row_q <= depth_ok ? qr_q[ROW_W-1:0] : '0;
            out_sym_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/pppz_checker.sv @@
// scoreboard for the point plotter: tracks registers and frame, predicts and checks every result
`timescale 1ns / 1ps
module pppz_checker
  import pppz_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [23:0]          m_axis_tdata,
  output int                   errors_o,
  output int                   pending_o,
  output int                   drawn_cnt_o,
  output int                   read_cnt_o
);

  logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
  logic [FOCAL_W-1:0]        focal;
  logic [SYM_W-1:0]          frame_sym [CELL_COUNT];
  logic [DEPTH_W-1:0]        frame_depth [CELL_COUNT];
  logic [23:0]               results_due [$];

  // fields of the result, lowest first: drawn, screen_col, screen_row, cell_symbol
  function automatic logic [23:0] project_point(logic [95:0] d, logic rd);
    longint dx, dy, dz, nc, nr, c, r, idx, dep;
    logic [23:0] res;
    res = '0;
    if (rd) begin
      c = d[86:80];
      r = d[92:87];
      if (c < SCREEN_COLS && r < SCREEN_ROWS) begin
        idx = r * SCREEN_COLS + c;
        res[21:14] = frame_sym[idx];
        frame_sym[idx] = BLANK_SYM;
        frame_depth[idx] = FAR_DEPTH;
      end
    end else begin
      dx = longint'($signed(d[23:0])) - longint'(cam_x);
      dy = longint'($signed(d[47:24])) - longint'(cam_y);
      dz = longint'($signed(d[71:48])) - longint'(cam_z);
      if (dz >= MIN_DZ) begin
        nc = dx * longint'(focal) + (SCREEN_COLS / 2) * dz;
        nr = dy * longint'(focal) + (SCREEN_ROWS / 2) * dz;
        if (nc >= 0 && nr >= 0) begin
          c = nc / dz;
          r = nr / dz;
          if (c < SCREEN_COLS && r < SCREEN_ROWS) begin
            idx = r * SCREEN_COLS + c;
            if (dz < longint'(frame_depth[idx])) begin
              dep = (dz > 64'hFFFFFF) ? 64'hFFFFFF : dz;
              frame_sym[idx] = d[79:72];
              frame_depth[idx] = dep[DEPTH_W-1:0];
              res[0] = 1'b1;
              res[7:1] = c[COL_W-1:0];
              res[13:8] = r[ROW_W-1:0];
            end
          end
        end
      end
    end
    return res;
  endfunction

  assign pending_o = results_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [23:0] want;
    if (!rst_ni) begin
      cam_x <= CAM_X_RST;
      cam_y <= CAM_Y_RST;
      cam_z <= CAM_Z_RST;
      focal <= FOCAL_RST;
      for (int i = 0; i < CELL_COUNT; i++) begin
        frame_sym[i] = BLANK_SYM;
        frame_depth[i] = FAR_DEPTH;
      end
      results_due.delete();
      errors_o <= 0;
      drawn_cnt_o <= 0;
      read_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAM_X: cam_x <= cfg_data_i;
          REG_CAM_Y: cam_y <= cfg_data_i;
          REG_CAM_Z: cam_z <= cfg_data_i;
          REG_FOCAL: focal <= cfg_data_i[FOCAL_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(project_point(s_axis_tdata, s_axis_tuser));
        if (s_axis_tuser) read_cnt_o <= read_cnt_o + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors_o <= errors_o + 1;
        end else begin
          want = results_due.pop_front();
          if (want[0]) drawn_cnt_o <= drawn_cnt_o + 1;
          if (m_axis_tdata[0] !== want[0] || m_axis_tdata[7:1] !== want[7:1] ||
              m_axis_tdata[13:8] !== want[13:8] || m_axis_tdata[21:14] !== want[21:14] ||
              m_axis_tdata[23:22] !== 2'b00) begin
            $display("%0t: mismatch expected drawn=%0d col=%0d row=%0d sym=%0d actual %h",
                     $time, want[0], want[7:1], want[13:8], want[21:14], m_axis_tdata);
            $display("%0t:   actual drawn=%0d col=%0d row=%0d sym=%0d", $time,
                     m_axis_tdata[0], m_axis_tdata[7:1], m_axis_tdata[13:8],
                     m_axis_tdata[21:14]);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
// top of the plotter testbench: clock, reset, stimulus, backpressure and verdict
`timescale 1ns / 1ps
module testbench;
  import pppz_pkg::*;

  localparam logic MODE_PLOT = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam int   WATCH_LIMIT = 20000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_CAM_X;
  logic [COORD_W-1:0]   cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [95:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = MODE_PLOT;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;

  int errors, pending, drawn_cnt, read_cnt;
  int tx_idle = 34, rx_idle = 50;
  logic hold_go = 1'b0, hold_seen = 1'b0;
  int hold_cnt = 0, quiet = 0;
  longint cam_x = 0, cam_y = -1280, cam_z = -2560, focal = 50;

  always #5 clk_i = ~clk_i;

  perspective_point_plot_zbuffer_top dut (.*);

  pppz_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending), .drawn_cnt_o(drawn_cnt), .read_cnt_o(read_cnt)
  );

  // result side, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic md, longint x, longint y, longint z, int sym, int col, int row);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= md;
    s_axis_tdata <= {3'b000, 6'(row), 7'(col), 8'(sym), 24'(z), 24'(y), 24'(x)};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 24'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CAM_X: cam_x = longint'($signed(24'(val)));
      REG_CAM_Y: cam_y = longint'($signed(24'(val)));
      REG_CAM_Z: cam_z = longint'($signed(24'(val)));
      default:   focal = val & 8'hFF;
    endcase
  endtask

  task automatic set_camera(longint x, longint y, longint z, longint f);
    write_reg(REG_CAM_X, x);
    write_reg(REG_CAM_Y, y);
    write_reg(REG_CAM_Z, z);
    write_reg(REG_FOCAL, f);
  endtask

  // half of the items are points aimed at a chosen cell, the rest reads of recent or random cells and raw noise
  task automatic random_items(int n);
    longint dz, dx, dy;
    int c, r, lc, lr, pick;
    lc = 60;
    lr = 20;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        c = ($urandom_range(3) == 0) ? lc : $urandom_range(SCREEN_COLS - 1);
        r = ($urandom_range(3) == 0) ? lr : $urandom_range(SCREEN_ROWS - 1);
        dz = ($urandom_range(9) == 0) ? $urandom_range(300000, 26) : $urandom_range(4000, 26);
        dx = ((c - SCREEN_COLS / 2) * dz + dz / 2) / focal;
        dy = ((r - SCREEN_ROWS / 2) * dz + dz / 2) / focal;
        send(MODE_PLOT, cam_x + dx, cam_y + dy, cam_z + dz, $urandom_range(255), 0, 0);
        lc = c;
        lr = r;
      end else if (pick < 80) begin
        if ($urandom_range(4) == 0) send(MODE_READ, 0, 0, 0, 0, $urandom_range(127),
                                         $urandom_range(63));
        else send(MODE_READ, 0, 0, 0, 0, lc, lr);
      end else begin
        send($urandom_range(1), $urandom, $urandom, $urandom, $urandom_range(255),
             $urandom_range(127), $urandom_range(63));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plot at the center, at the minimum depth and too close
    send(MODE_PLOT, 0, -1280, 0, 65, 0, 0);
    send(MODE_PLOT, 0, -1280, -2560 + 26, 66, 0, 0);
    send(MODE_PLOT, 0, -1280, -2560 + 25, 67, 0, 0);
    send(MODE_PLOT, 0, -1280, -2560, 68, 0, 0);
    send(MODE_PLOT, 0, -1280, -8388608, 69, 0, 0);
    // negative numerator, off screen, failed depth test
    send(MODE_PLOT, -8388608, -1280, 0, 70, 0, 0);
    send(MODE_PLOT, 0, -8388608, 0, 71, 0, 0);
    send(MODE_PLOT, 8388607, -1280, 0, 72, 0, 0);
    send(MODE_PLOT, 0, 8388607, 0, 73, 0, 0);
    send(MODE_PLOT, 0, -1280, 8388607, 255, 0, 0);
    send(MODE_PLOT, 0, -1280, 100, 0, 0, 0);
    send(MODE_PLOT, 0, -1280, -1000, 255, 0, 0);
    send(MODE_PLOT, -8388608, -8388608, 8388607, 255, 0, 0);
    // reads: touched cell, cleared cell, corners, outside the frame
    send(MODE_READ, 0, 0, 0, 0, 60, 20);
    send(MODE_READ, 0, 0, 0, 0, 60, 20);
    send(MODE_READ, 0, 0, 0, 0, 0, 0);
    send(MODE_READ, 0, 0, 0, 0, 119, 39);
    send(MODE_READ, 0, 0, 0, 0, 120, 0);
    send(MODE_READ, 0, 0, 0, 0, 0, 40);
    send(MODE_READ, -1, -1, -1, 255, 127, 63);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = (ph < 2) ? 34 : (ph < 4) ? 50 : 0;
      rx_idle = (ph < 2) ? 50 : (ph < 4) ? 34 : 0;
      case (ph)
        1: set_camera(-8388608, -8388608, -8388608, 255);
        2: set_camera(8388607, 8388607, 8388607, 1);
        3: set_camera($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                      $urandom_range(8000) - 4000, $urandom_range(255, 1));
        4: set_camera(-5000000, 3000000, -2560, 128);
        5: set_camera(0, -1280, -2560, 50);
        default: ;
      endcase
      if (ph == 4) begin
        random_items(40);
        hold_go <= 1'b1;
        random_items(110);
      end else begin
        random_items(150);
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    $display("covered %0d reads and %0d drawn points over six camera settings,", read_cnt,
             drawn_cnt);
    $display("with sender and receiver stalls, one long result hold-off and drains");
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
